// ----- rtl/mpm_pkg.sv -----
// Shared types, constants and compare functions for the multichannel peak meter.
// Depends on nothing; every other file of the block uses it by scoped names.
package mpm_pkg;

    localparam int LANE_COUNT       = 8;
    localparam int SAMPLE_W         = 32;
    localparam int COUNT_W          = 4;
    localparam int CHAN_IDX_W       = 3;
    localparam int CFG_INDEX_W      = 4;
    localparam int CFG_DATA_W       = 8;
    localparam int MAX_CHANNELS_DEF = 8;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_COUNT = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_FORMAT = 4'd1;

    localparam logic FMT_F32 = 1'b0;
    localparam logic FMT_S16 = 1'b1;

    localparam logic [COUNT_W-1:0] CHANNEL_COUNT_RST = 4'd4;

    typedef struct packed {
        logic [SAMPLE_W-1:0] lane0_sample;
        logic [SAMPLE_W-1:0] lane1_sample;
        logic [SAMPLE_W-1:0] lane2_sample;
        logic [SAMPLE_W-1:0] lane3_sample;
        logic [SAMPLE_W-1:0] lane4_sample;
        logic [SAMPLE_W-1:0] lane5_sample;
        logic [SAMPLE_W-1:0] lane6_sample;
        logic [SAMPLE_W-1:0] lane7_sample;
        logic                last_frame;
    } t_in_item;

    typedef struct packed {
        logic [CHAN_IDX_W-1:0] channel_index;
        logic [SAMPLE_W-1:0]   peak_value;
        logic                  last_peak;
    } t_out_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic f32_is_nan(input logic [SAMPLE_W-1:0] v);
        return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
    endfunction

    function automatic logic [SAMPLE_W-1:0] f32_key(input logic [SAMPLE_W-1:0] v);
        return v[31] ? ~v : {1'b1, v[30:0]};
    endfunction

    // IEEE ordered a < b on single-precision bit patterns.
    function automatic logic f32_less(input logic [SAMPLE_W-1:0] a,
                                      input logic [SAMPLE_W-1:0] b);
        logic res;
        res = 1'b0;
        if (!f32_is_nan(a) && !f32_is_nan(b) && ((a[30:0] | b[30:0]) != 31'd0)) begin
            res = f32_key(a) < f32_key(b);
        end
        return res;
    endfunction

endpackage

// ----- rtl/mpm_front.sv -----
// Front part: configuration registers, per-channel peak update and report snapshot.
// Depends on mpm_pkg; pushes one report per last frame into mpm_queue.
module mpm_front #(
    parameter int MAX_CHANNELS = mpm_pkg::MAX_CHANNELS_DEF,
    parameter int PEAKS        = (MAX_CHANNELS < mpm_pkg::LANE_COUNT)
                                 ? MAX_CHANNELS : mpm_pkg::LANE_COUNT,
    parameter int REPORT_W     = PEAKS * mpm_pkg::SAMPLE_W + mpm_pkg::COUNT_W
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  mpm_pkg::t_in_item                  i_in_item,
    input  logic                               i_cfg_valid,
    input  logic [mpm_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [mpm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  mpm_pkg::t_q_status                 i_q_status,
    output logic                               o_push,
    output logic [REPORT_W-1:0]                o_report
);

    logic [mpm_pkg::COUNT_W-1:0]                    r_channel_count;
    logic                                           r_sample_format;
    logic                                           r_fresh;
    logic [PEAKS-1:0][mpm_pkg::SAMPLE_W-1:0]        r_peak;
    logic [PEAKS-1:0][mpm_pkg::SAMPLE_W-1:0]        n_peak;
    logic [PEAKS-1:0][mpm_pkg::SAMPLE_W-1:0]        w_snap;
    logic [mpm_pkg::LANE_COUNT-1:0][mpm_pkg::SAMPLE_W-1:0] w_lane;
    logic [mpm_pkg::COUNT_W-1:0]                    w_active;
    logic                                           w_accept;

    assign w_lane[0] = i_in_item.lane0_sample;
    assign w_lane[1] = i_in_item.lane1_sample;
    assign w_lane[2] = i_in_item.lane2_sample;
    assign w_lane[3] = i_in_item.lane3_sample;
    assign w_lane[4] = i_in_item.lane4_sample;
    assign w_lane[5] = i_in_item.lane5_sample;
    assign w_lane[6] = i_in_item.lane6_sample;
    assign w_lane[7] = i_in_item.lane7_sample;

    always_comb begin
        priority if (r_channel_count == '0) begin
            w_active = mpm_pkg::COUNT_W'(1);
        end else if (r_channel_count > mpm_pkg::COUNT_W'(PEAKS)) begin
            w_active = mpm_pkg::COUNT_W'(PEAKS);
        end else begin
            w_active = r_channel_count;
        end
    end

    assign o_in_stall = i_q_status.full && i_in_item.last_frame;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        logic [mpm_pkg::SAMPLE_W-1:0] base;
        logic [mpm_pkg::SAMPLE_W-1:0] s;
        logic                         take;
        for (int k = 0; k < PEAKS; k++) begin
            base = r_fresh ? '0 : r_peak[k];
            s    = w_lane[k];
            if (r_sample_format == mpm_pkg::FMT_S16) begin
                take = !($signed(s[15:0]) < $signed(base[15:0]));
            end else begin
                take = !mpm_pkg::f32_less(s, base);
            end
            n_peak[k] = base;
            if ((mpm_pkg::COUNT_W'(k) < w_active) && take) begin
                n_peak[k] = (r_sample_format == mpm_pkg::FMT_S16) ? {16'd0, s[15:0]} : s;
            end
            w_snap[k] = (r_sample_format == mpm_pkg::FMT_S16)
                        ? {16'd0, n_peak[k][15:0]} : n_peak[k];
        end
    end

    assign o_push   = w_accept && i_in_item.last_frame;
    assign o_report = {w_active, w_snap};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count <= mpm_pkg::CHANNEL_COUNT_RST;
            r_sample_format <= mpm_pkg::FMT_F32;
            r_fresh         <= 1'b1;
        end else begin
            if (i_cfg_valid && (i_cfg_index == mpm_pkg::CFG_CHANNEL_COUNT)) begin
                r_channel_count <= i_cfg_data[mpm_pkg::COUNT_W-1:0];
            end
            if (i_cfg_valid && (i_cfg_index == mpm_pkg::CFG_SAMPLE_FORMAT)) begin
                r_sample_format <= i_cfg_data[0];
            end
            if (w_accept) begin
                r_fresh <= i_in_item.last_frame;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_peak <= n_peak;
        end
    end

endmodule

// ----- rtl/mpm_queue.sv -----
// Short report queue between the front and back parts of the peak meter.
// Depends on mpm_pkg for its depth and status struct.
module mpm_queue #(
    parameter int WIDTH = 36
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [WIDTH-1:0]   i_data,
    input  logic               i_pop,
    output logic [WIDTH-1:0]   o_data,
    output mpm_pkg::t_q_status o_status
);

    localparam int PTR_W = (mpm_pkg::QUEUE_DEPTH > 1) ? $clog2(mpm_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(mpm_pkg::QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [mpm_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_status.full  = (r_cnt == CNT_W'(mpm_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign o_data         = r_mem[r_rd];
    assign w_push         = i_push && !o_status.full;
    assign w_pop          = i_pop && !o_status.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_W'(mpm_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(mpm_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            unique case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ----- rtl/mpm_back.sv -----
// Back part: walks the report at the queue head and emits one result beat per channel.
// Depends on mpm_pkg; pops mpm_queue as the last channel's beat is taken.
module mpm_back #(
    parameter int MAX_CHANNELS = mpm_pkg::MAX_CHANNELS_DEF,
    parameter int PEAKS        = (MAX_CHANNELS < mpm_pkg::LANE_COUNT)
                                 ? MAX_CHANNELS : mpm_pkg::LANE_COUNT,
    parameter int REPORT_W     = PEAKS * mpm_pkg::SAMPLE_W + mpm_pkg::COUNT_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [REPORT_W-1:0]   i_report,
    input  mpm_pkg::t_q_status    i_q_status,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output mpm_pkg::t_out_item    o_out_item
);

    localparam int IDX_W = (PEAKS > 1) ? $clog2(PEAKS) : 1;

    logic [mpm_pkg::CHAN_IDX_W-1:0]           r_idx;
    logic [PEAKS-1:0][mpm_pkg::SAMPLE_W-1:0]  w_peaks;
    logic [mpm_pkg::COUNT_W-1:0]              w_count;
    logic                                     w_last;
    logic                                     w_take;

    assign w_peaks = i_report[PEAKS*mpm_pkg::SAMPLE_W-1:0];
    assign w_count = i_report[REPORT_W-1 -: mpm_pkg::COUNT_W];
    assign w_last  = ({1'b0, r_idx} + mpm_pkg::COUNT_W'(1)) == w_count;

    assign o_out_valid              = !i_q_status.empty;
    assign o_out_item.channel_index = r_idx;
    assign o_out_item.peak_value    = w_peaks[r_idx[IDX_W-1:0]];
    assign o_out_item.last_peak     = w_last;

    assign w_take = o_out_valid && !i_out_stall;
    assign o_pop  = w_take && w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (w_take) begin
            r_idx <= w_last ? '0 : r_idx + 1'b1;
        end
    end

endmodule

// ----- rtl/multichannel_peak_meter.sv -----
// Top level of the multichannel peak meter: front, report queue and back.
// Depends on mpm_pkg, mpm_front, mpm_queue and mpm_back.
//
// Channel   Direction  Handshake            Beat
// in        to block   i_in_valid/o_in_stall  one frame of eight lanes and a last flag
// out       from block o_out_valid/i_out_stall one channel peak
// cfg       to block   i_cfg_valid/o_cfg_ready register index and write data
//
// A frame is taken every cycle unless o_in_stall holds it; its peaks are updated in the cycle it is accepted.
// A last frame queues a report, and the back emits one result per active channel per cycle while i_out_stall is low.
// A last frame stalls only while two reports are already waiting in the queue.
// Reset is synchronous; peaks read as zero through the fresh-buffer flag, with no clearing pass.
module multichannel_peak_meter #(
    parameter int MAX_CHANNELS = mpm_pkg::MAX_CHANNELS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  mpm_pkg::t_in_item               i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output mpm_pkg::t_out_item              o_out_item,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mpm_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [mpm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int PEAKS    = (MAX_CHANNELS < mpm_pkg::LANE_COUNT)
                              ? MAX_CHANNELS : mpm_pkg::LANE_COUNT;
    localparam int REPORT_W = PEAKS * mpm_pkg::SAMPLE_W + mpm_pkg::COUNT_W;

    logic                 w_push;
    logic                 w_pop;
    logic [REPORT_W-1:0]  w_report_in;
    logic [REPORT_W-1:0]  w_report_out;
    mpm_pkg::t_q_status   w_q_status;

    assign o_cfg_ready = 1'b1;

    mpm_front #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .PEAKS        (PEAKS),
        .REPORT_W     (REPORT_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_status  (w_q_status),
        .o_push      (w_push),
        .o_report    (w_report_in)
    );

    mpm_queue #(
        .WIDTH (REPORT_W)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_data   (w_report_in),
        .i_pop    (w_pop),
        .o_data   (w_report_out),
        .o_status (w_q_status)
    );

    mpm_back #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .PEAKS        (PEAKS),
        .REPORT_W     (REPORT_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_report    (w_report_out),
        .i_q_status  (w_q_status),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
